// File: src/rhc_pkg.sv
package rhc_pkg;

  // fixed field widths of the pixel ports
  localparam int PIX_W = 8;
  localparam int HUE_W = 13;
  localparam int SAT_W = 8;
  localparam int VAL_W = 8;

  // one hue sector in whole degrees
  localparam int DEG_PER_SECTOR = 60;

  // sector picked by the largest channel
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // per-pixel hue control that rides along the divider pipeline
  typedef struct packed {
    logic    neg;
    logic    grey;
    sector_t sector;
  } hue_ctl_t;

endpackage

// File: src/rhc_div_pipe.sv
module rhc_div_pipe #(
  parameter int CHAN_W = 8,
  parameter int HQ_W   = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [HQ_W+CHAN_W-1:0]   hue_num,
  input  logic [CHAN_W-1:0]        delta,
  input  logic [2*CHAN_W-1:0]      sat_num,
  input  logic [CHAN_W-1:0]        val,
  input  rhc_pkg::hue_ctl_t        ctl_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [HQ_W-1:0]          hue_quo,
  output logic                     hue_rem_nz,
  output logic [CHAN_W-1:0]        sat_quo,
  output logic [CHAN_W-1:0]        val_q,
  output rhc_pkg::hue_ctl_t        ctl_out
);

  // one restoring step per stage for both quotients
  localparam int NS = (HQ_W > CHAN_W) ? HQ_W : CHAN_W;

  logic                vld   [NS];
  logic                rdy   [NS+1];
  logic [CHAN_W-1:0]   h_rem [NS];
  logic [HQ_W-1:0]     h_lq  [NS];
  logic [CHAN_W-1:0]   s_rem [NS];
  logic [CHAN_W-1:0]   s_lq  [NS];
  logic [CHAN_W-1:0]   dlt   [NS];
  logic [CHAN_W-1:0]   vl    [NS];
  rhc_pkg::hue_ctl_t   ctl   [NS];

  assign rdy[NS] = out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [CHAN_W-1:0] hr;
    logic [HQ_W-1:0]   hl;
    logic [CHAN_W-1:0] sr;
    logic [CHAN_W-1:0] sl;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] v;
    rhc_pkg::hue_ctl_t c;
    logic              sv;
    logic [CHAN_W-1:0] hr_next;
    logic [HQ_W-1:0]   hl_next;
    logic [CHAN_W-1:0] sr_next;
    logic [CHAN_W-1:0] sl_next;

    // stage source: split numerators at entry, previous stage otherwise
    if (s == 0) begin : g_src_in
      assign hr = hue_num[HQ_W +: CHAN_W];
      assign hl = hue_num[HQ_W-1:0];
      assign sr = sat_num[CHAN_W +: CHAN_W];
      assign sl = sat_num[CHAN_W-1:0];
      assign d  = delta;
      assign v  = val;
      assign c  = ctl_in;
      assign sv = in_valid;
    end else begin : g_src_prev
      assign hr = h_rem[s-1];
      assign hl = h_lq[s-1];
      assign sr = s_rem[s-1];
      assign sl = s_lq[s-1];
      assign d  = dlt[s-1];
      assign v  = vl[s-1];
      assign c  = ctl[s-1];
      assign sv = vld[s-1];
    end

    // hue step: divide by delta
    if (s < HQ_W) begin : g_hue_step
      logic [CHAN_W:0] ht;
      logic            hge;
      assign ht      = {hr, hl[HQ_W-1]};
      assign hge     = ht >= {1'b0, d};
      assign hr_next = hge ? CHAN_W'(ht - {1'b0, d}) : CHAN_W'(ht);
      assign hl_next = {hl[HQ_W-2:0], hge};
    end else begin : g_hue_hold
      assign hr_next = hr;
      assign hl_next = hl;
    end

    // saturation step: divide by value
    if (s < CHAN_W) begin : g_sat_step
      logic [CHAN_W:0] st;
      logic            sge;
      assign st      = {sr, sl[CHAN_W-1]};
      assign sge     = st >= {1'b0, v};
      assign sr_next = sge ? CHAN_W'(st - {1'b0, v}) : CHAN_W'(st);
      assign sl_next = {sl[CHAN_W-2:0], sge};
    end else begin : g_sat_hold
      assign sr_next = sr;
      assign sl_next = sl;
    end

    // stage takes a beat when empty or when the next stage moves
    assign rdy[s] = !vld[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && sv) begin
        h_rem[s] <= hr_next;
        h_lq[s]  <= hl_next;
        s_rem[s] <= sr_next;
        s_lq[s]  <= sl_next;
        dlt[s]   <= d;
        vl[s]    <= v;
        ctl[s]   <= c;
      end
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = vld[NS-1];
  assign hue_quo    = h_lq[NS-1];
  assign hue_rem_nz = |h_rem[NS-1];
  assign sat_quo    = s_lq[NS-1];
  assign val_q      = vl[NS-1];
  assign ctl_out    = ctl[NS-1];

endmodule

// File: src/rgb_to_hsv_convert.sv
// RGB to HSV pixel converter. Takes one 8-bit RGB pixel per clock and returns value (the
// largest channel), saturation (255 * delta / value, rounded down) and hue in sixteenths
// of a degree (0..5759), with grey pixels giving hue and saturation 0 and ties in the
// largest channel going to red, then green, then blue. Throughput is one pixel every
// clock while hsv_stall does not hold the output. The pipeline runs through stage a, stage
// b, the two restoring dividers and the output register; the dividers retire one quotient
// bit per pipeline stage, HQ = clog2(60 * 2^HUE_FRAC_BITS + 1) bits of hue and CHANNEL_BITS
// bits of saturation. pix_stall follows hsv_stall only when the pipeline is full.
module rgb_to_hsv_convert #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic [rhc_pkg::PIX_W-1:0] red_in,
  input  logic [rhc_pkg::PIX_W-1:0] green_in,
  input  logic [rhc_pkg::PIX_W-1:0] blue_in,
  output logic                      hsv_valid,
  input  logic                      hsv_stall,
  output logic [rhc_pkg::HUE_W-1:0] hue_out,
  output logic [rhc_pkg::SAT_W-1:0] sat_out,
  output logic [rhc_pkg::VAL_W-1:0] val_out
);

  localparam int CB        = CHANNEL_BITS;
  localparam int HUE_SIXTH = rhc_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS;
  localparam int HQ_W      = $clog2(HUE_SIXTH + 1);
  localparam int HN_W      = HQ_W + CB;
  localparam int HS_W      = HQ_W + 4;
  localparam int HUE_W     = rhc_pkg::HUE_W;
  localparam int SAT_W     = rhc_pkg::SAT_W;
  localparam int VAL_W     = rhc_pkg::VAL_W;

  // ready chain back from the output register
  logic o_rdy;
  logic a_rdy;
  logic b_rdy;
  logic div_rdy;

  // stage a: max, min, sector and signed channel difference
  logic [CB-1:0]    r;
  logic [CB-1:0]    g;
  logic [CB-1:0]    b;
  logic [CB-1:0]    hi;
  logic [CB-1:0]    lo;
  logic [CB-1:0]    x;
  logic [CB-1:0]    y;
  logic             neg;
  rhc_pkg::sector_t sector;

  logic             a_vld;
  logic [CB-1:0]    a_val;
  logic [CB-1:0]    a_delta;
  logic [CB-1:0]    a_mag;
  logic             a_neg;
  rhc_pkg::sector_t a_sector;

  assign r = CB'(red_in);
  assign g = CB'(green_in);
  assign b = CB'(blue_in);

  always_comb begin
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    if (hi == r) begin
      sector = rhc_pkg::SECT_RED;
      x      = g;
      y      = b;
    end else if (hi == g) begin
      sector = rhc_pkg::SECT_GREEN;
      x      = b;
      y      = r;
    end else begin
      sector = rhc_pkg::SECT_BLUE;
      x      = r;
      y      = g;
    end
    neg = y > x;
  end

  assign a_rdy     = !a_vld || b_rdy;
  assign pix_stall = !a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_rdy) begin
      a_vld <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && pix_valid) begin
      a_val    <= hi;
      a_delta  <= hi - lo;
      a_mag    <= neg ? (y - x) : (x - y);
      a_neg    <= neg;
      a_sector <= sector;
    end
  end

  // stage b: scaled numerators for both divisions
  logic              b_vld;
  logic [HN_W-1:0]   b_hnum;
  logic [2*CB-1:0]   b_snum;
  logic [CB-1:0]     b_delta;
  logic [CB-1:0]     b_val;
  rhc_pkg::hue_ctl_t b_ctl;

  assign b_rdy = !b_vld || div_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_rdy) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_vld) begin
      b_hnum        <= HN_W'(HUE_SIXTH) * HN_W'(a_mag);
      b_snum        <= {a_delta, CB'(0)} - {CB'(0), a_delta};
      b_delta       <= a_delta;
      b_val         <= a_val;
      b_ctl.neg     <= a_neg;
      b_ctl.grey    <= a_delta == CB'(0);
      b_ctl.sector  <= a_sector;
    end
  end

  // divider pipeline
  logic              d_vld;
  logic [HQ_W-1:0]   d_hq;
  logic              d_nz;
  logic [CB-1:0]     d_sq;
  logic [CB-1:0]     d_val;
  rhc_pkg::hue_ctl_t d_ctl;

  rhc_div_pipe #(
    .CHAN_W (CB),
    .HQ_W   (HQ_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_vld),
    .in_ready   (div_rdy),
    .hue_num    (b_hnum),
    .delta      (b_delta),
    .sat_num    (b_snum),
    .val        (b_val),
    .ctl_in     (b_ctl),
    .out_valid  (d_vld),
    .out_ready  (o_rdy),
    .hue_quo    (d_hq),
    .hue_rem_nz (d_nz),
    .sat_quo    (d_sq),
    .val_q      (d_val),
    .ctl_out    (d_ctl)
  );

  // output stage: floor rounding, sector offset, wrap and grey zeroing
  logic signed [HS_W-1:0] base;
  logic signed [HS_W-1:0] mag_s;
  logic signed [HS_W-1:0] hue_s;
  logic [HS_W-1:0]        hue_fix;

  always_comb begin
    unique case (d_ctl.sector)
      rhc_pkg::SECT_RED:   base = '0;
      rhc_pkg::SECT_GREEN: base = HS_W'(2 * HUE_SIXTH);
      rhc_pkg::SECT_BLUE:  base = HS_W'(4 * HUE_SIXTH);
      default:             base = '0;
    endcase
    mag_s = $signed(HS_W'(d_hq) + ((d_ctl.neg && d_nz) ? HS_W'(1) : HS_W'(0)));
    hue_s = d_ctl.neg ? (base - mag_s) : (base + mag_s);
    if (hue_s < 0) hue_s = hue_s + $signed(HS_W'(6 * HUE_SIXTH));
    hue_fix = d_ctl.grey ? '0 : $unsigned(hue_s);
  end

  assign o_rdy = !hsv_valid || !hsv_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (o_rdy) begin
      hsv_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && d_vld) begin
      hue_out <= HUE_W'(hue_fix);
      sat_out <= d_ctl.grey ? '0 : SAT_W'(d_sq);
      val_out <= VAL_W'(d_val);
    end
  end

endmodule

// File: bench/hsv_checker.sv
`timescale 1ns / 1ps

module hsv_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  input  logic                      pix_stall,
  input  logic [rhc_pkg::PIX_W-1:0] red_in,
  input  logic [rhc_pkg::PIX_W-1:0] green_in,
  input  logic [rhc_pkg::PIX_W-1:0] blue_in,
  input  logic                      hsv_valid,
  input  logic                      hsv_stall,
  input  logic [rhc_pkg::HUE_W-1:0] hue_out,
  input  logic [rhc_pkg::SAT_W-1:0] sat_out,
  input  logic [rhc_pkg::VAL_W-1:0] val_out,
  output int                        mismatches,
  output int                        pending,
  output int                        checked
);

  localparam int PIX_W       = rhc_pkg::PIX_W;
  localparam int HUE_W       = rhc_pkg::HUE_W;
  localparam int SAT_W       = rhc_pkg::SAT_W;
  localparam int VAL_W       = rhc_pkg::VAL_W;
  localparam int FRAC_BITS   = 4;
  localparam int SIXTH       = rhc_pkg::DEG_PER_SECTOR << FRAC_BITS;
  localparam int FULL_SCALE  = (1 << PIX_W) - 1;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] val;
  } hsv_t;

  // converted pixels still owed by the block, oldest first
  hsv_t hsv_expected[$];

  // integer division rounding toward minus infinity, den > 0
  function automatic int div_floor(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic hsv_t predict_hsv(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                       logic [PIX_W-1:0] b);
    int               rr;
    int               gg;
    int               bb;
    int               hi;
    int               lo;
    int               delta;
    int               hue;
    int               sat;
    rhc_pkg::sector_t sect;
    hsv_t             res;
    rr = r;
    gg = g;
    bb = b;
    hi = rr;
    lo = rr;
    if (gg > hi) hi = gg;
    if (bb > hi) hi = bb;
    if (gg < lo) lo = gg;
    if (bb < lo) lo = bb;
    delta = hi - lo;
    hue = 0;
    sat = 0;
    // grey pixels keep hue and saturation at zero
    if (delta > 0) begin
      // ties in the largest channel go red, then green, then blue
      if (hi == rr) sect = rhc_pkg::SECT_RED;
      else if (hi == gg) sect = rhc_pkg::SECT_GREEN;
      else sect = rhc_pkg::SECT_BLUE;
      case (sect)
        rhc_pkg::SECT_RED:   hue = div_floor(SIXTH * (gg - bb), delta);
        rhc_pkg::SECT_GREEN: hue = div_floor(SIXTH * (bb - rr), delta) + 2 * SIXTH;
        default:             hue = div_floor(SIXTH * (rr - gg), delta) + 4 * SIXTH;
      endcase
      if (hue < 0) hue += 6 * SIXTH;
      sat = (FULL_SCALE * delta) / hi;
    end
    res.hue = hue[HUE_W-1:0];
    res.sat = sat[SAT_W-1:0];
    res.val = hi[VAL_W-1:0];
    return res;
  endfunction

  // predict on each input beat, compare on each output beat
  always @(posedge clk) begin : watch
    hsv_t want;
    if (rst) begin
      hsv_expected.delete();
      pending <= 0;
    end else begin
      if (pix_valid && !pix_stall)
        hsv_expected.push_back(predict_hsv(red_in, green_in, blue_in));
      if (hsv_valid && !hsv_stall) begin
        if (hsv_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] unexpected beat: hue %0d sat %0d val %0d",
                     $realtime, hue_out, sat_out, val_out);
        end else begin
          want = hsv_expected.pop_front();
          checked++;
          if (want.hue !== hue_out || want.sat !== sat_out || want.val !== val_out) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"[%0t] mismatch: expected hue %0d sat %0d val %0d,",
                        " got hue %0d sat %0d val %0d"},
                       $realtime, want.hue, want.sat, want.val, hue_out, sat_out, val_out);
          end
        end
      end
      pending <= hsv_expected.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int PIX_W         = rhc_pkg::PIX_W;
  localparam int HUE_W         = rhc_pkg::HUE_W;
  localparam int SAT_W         = rhc_pkg::SAT_W;
  localparam int VAL_W         = rhc_pkg::VAL_W;
  localparam int RANDOM_PIXELS = 400;
  localparam int QUIET_FIRST   = 150;
  localparam int QUIET_LAST    = 270;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             pix_valid = 1'b0;
  logic             hsv_stall = 1'b0;
  logic             quiet     = 1'b0;
  logic [PIX_W-1:0] red_in    = '0;
  logic [PIX_W-1:0] green_in  = '0;
  logic [PIX_W-1:0] blue_in   = '0;
  logic             pix_stall;
  logic             hsv_valid;
  logic [HUE_W-1:0] hue_out;
  logic [SAT_W-1:0] sat_out;
  logic [VAL_W-1:0] val_out;
  int               mismatches;
  int               pending;
  int               checked;
  int               cycle_count = 0;
  int               sent        = 0;
  int               directed    = 0;

  always #4 clk = ~clk;

  rgb_to_hsv_convert dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out)
  );

  hsv_checker hsv_check (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue_out    (hue_out),
    .sat_out    (sat_out),
    .val_out    (val_out),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // output side back-pressure, off during the quiet stretch
  always @(posedge clk) begin
    hsv_stall <= !quiet && ($urandom_range(0, 99) < 10);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    sent++;
  endtask

  // mostly uniform pixels, with greys, tied maxima and near-greys mixed in
  task automatic send_random_pixel();
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    int               base;
    a = PIX_W'($urandom);
    b = PIX_W'($urandom);
    c = PIX_W'($urandom);
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    base = $urandom_range(0, 250);
    case ($urandom_range(0, 9))
      0: send_pixel(a, a, a);
      1, 2: begin
        case ($urandom_range(0, 2))
          0: send_pixel(hi, hi, lo);
          1: send_pixel(hi, lo, hi);
          default: send_pixel(lo, hi, hi);
        endcase
      end
      3: send_pixel(PIX_W'(base + $urandom_range(0, 5)), PIX_W'(base + $urandom_range(0, 5)),
                    PIX_W'(base + $urandom_range(0, 5)));
      default: send_pixel(a, b, c);
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // black, white and grey
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    // primaries
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // tied maxima: red over green, green over blue, red over blue
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd90, 8'd90, 8'd89);
    // red sector just below zero, wraps to the top of the circle
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd11);
    // saturation extremes
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd0, 8'd1, 8'd1);
    // assorted sectors, the last two with alternating bit patterns
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd85, 8'd170, 8'd255);
    directed = sent;

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      quiet <= (i >= QUIET_FIRST) && (i < QUIET_LAST);
      send_random_pixel();
    end
    pix_valid <= 1'b0;
    quiet     <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels converted, %0d directed (greys, tied maxima, hue wrap, saturation ends)",
             sent, directed);
    $display("%0d results compared under random throttling on both sides, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
